// ----- rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and codes for the text console character writer: input modes,
// decoded operations, the command and result words and the back-end states.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] BLANK_ATTR   = 8'h0F;

    // width that holds row * COLUMNS + col over the whole parameter range
    localparam int POS_FULL_W = 13;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_MOVE,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_REPORT
    } back_state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [7:0] attr;
        logic [5:0] row;
        logic [6:0] col;
        logic       on_screen;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } result_t;

endpackage

// ----- rtl/tccw_fifo.sv -----
// ----------------------------------------------------------------------------
// tccw_fifo
// Two-entry register queue; used between front and back end and again as the
// result buffer in front of the output ports.
// ----------------------------------------------------------------------------
module tccw_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/tccw_front.sv -----
// ----------------------------------------------------------------------------
// tccw_front
// Front end: classifies an incoming word into a decoded operation and checks
// whether its target position lies on the screen.
// ----------------------------------------------------------------------------
module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [1:0]     mode,
    input  logic [7:0]     char_code,
    input  logic [7:0]     attr,
    input  logic [5:0]     row,
    input  logic [6:0]     col,
    output tccw_pkg::cmd_t cmd
);

    always_comb
    begin
        cmd.char_code = char_code;
        cmd.attr      = attr;
        cmd.row       = row;
        cmd.col       = col;
        cmd.on_screen = ({1'b0, row} < 7'(ROWS)) && ({1'b0, col} < 8'(COLUMNS));
        case (mode)
            tccw_pkg::MODE_PUT:
            begin
                if (char_code == tccw_pkg::CH_NEWLINE)
                begin
                    cmd.op = tccw_pkg::OP_NEWLINE;
                end
                else if (char_code == tccw_pkg::CH_BACKSPACE)
                begin
                    cmd.op = tccw_pkg::OP_BACKSPACE;
                end
                else
                begin
                    cmd.op = tccw_pkg::OP_PUT;
                end
            end
            tccw_pkg::MODE_CLEAR: cmd.op = tccw_pkg::OP_CLEAR;
            tccw_pkg::MODE_MOVE:  cmd.op = tccw_pkg::OP_MOVE;
            tccw_pkg::MODE_READ:  cmd.op = tccw_pkg::OP_READ;
            default:              cmd.op = tccw_pkg::OP_READ;
        endcase
    end

endmodule

// ----- rtl/tccw_back.sv -----
// ----------------------------------------------------------------------------
// tccw_back
// Back end: holds the cursor, the row-offset ring and the cell memory,
// carries out decoded operations, runs blanking sweeps and forms results.
// ----------------------------------------------------------------------------
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tccw_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output tccw_pkg::result_t res,
    output logic              init_busy
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);
    localparam logic [5:0] LAST_ROW = 6'(ROWS - 1);

    logic [15:0] mem [CELLS];
    logic [15:0] rd_q;

    tccw_pkg::back_state_t state_reg;
    tccw_pkg::back_state_t state_next;

    logic [6:0] cur_col_reg;
    logic [6:0] cur_col_next;
    logic [5:0] cur_row_reg;
    logic [5:0] cur_row_next;
    logic [5:0] top_reg;
    logic [5:0] top_next;
    logic [6:0] sweep_col_reg;
    logic [6:0] sweep_col_next;
    logic [5:0] sweep_row_reg;
    logic [5:0] sweep_row_next;
    logic [7:0] fill_attr_reg;
    logic [7:0] fill_attr_next;
    logic       ok_reg;
    logic       ok_next;
    logic       read_reg;
    logic       read_next;

    logic              mem_we;
    logic              mem_re;
    logic [15:0]       mem_wdata;
    logic [5:0]        tgt_row;
    logic [6:0]        tgt_col;
    logic              tgt_logical;
    logic [6:0]        phys_sum;
    logic [5:0]        phys_row;
    logic [tccw_pkg::POS_FULL_W-1:0] addr_full;
    logic [ADDR_W-1:0] addr;
    logic [tccw_pkg::POS_FULL_W-1:0] pos_full;
    logic              scroll_needed;
    logic              sweep_done;
    logic              top_wrap_zero;

    assign sweep_done    = (sweep_row_reg == LAST_ROW) && (sweep_col_reg == LAST_COL);
    assign top_wrap_zero = (top_reg == LAST_ROW);
    assign scroll_needed = (cur_row_reg == LAST_ROW) &&
                           ((cmd.op == tccw_pkg::OP_NEWLINE) ||
                            ((cmd.op == tccw_pkg::OP_PUT) && (cur_col_reg == LAST_COL)));
    assign init_busy     = (state_reg == tccw_pkg::ST_INIT);

    // logical row through the ring, then linear cell address
    always_comb
    begin
        phys_sum = 7'(tgt_row) + 7'(top_reg);
        if (tgt_logical && (phys_sum >= 7'(ROWS)))
        begin
            phys_row = 6'(phys_sum - 7'(ROWS));
        end
        else if (tgt_logical)
        begin
            phys_row = phys_sum[5:0];
        end
        else
        begin
            phys_row = tgt_row;
        end
        addr_full = tccw_pkg::POS_FULL_W'(phys_row) * tccw_pkg::POS_FULL_W'(COLUMNS)
                    + tccw_pkg::POS_FULL_W'(tgt_col);
        addr      = addr_full[ADDR_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                if (sweep_done)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (cmd.op == tccw_pkg::OP_CLEAR)
                    begin
                        state_next = tccw_pkg::ST_CLEAR;
                    end
                    else if (scroll_needed)
                    begin
                        state_next = tccw_pkg::ST_SCROLL;
                    end
                    else
                    begin
                        state_next = tccw_pkg::ST_REPORT;
                    end
                end
            end
            tccw_pkg::ST_CLEAR:
            begin
                if (sweep_done)
                begin
                    state_next = tccw_pkg::ST_REPORT;
                end
            end
            tccw_pkg::ST_SCROLL:
            begin
                if (sweep_col_reg == LAST_COL)
                begin
                    state_next = tccw_pkg::ST_REPORT;
                end
            end
            tccw_pkg::ST_REPORT:
            begin
                if (!res_full)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default: state_next = tccw_pkg::ST_INIT;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        sweep_col_next = sweep_col_reg;
        sweep_row_next = sweep_row_reg;
        fill_attr_next = fill_attr_reg;
        ok_next        = ok_reg;
        read_next      = read_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = {fill_attr_reg, tccw_pkg::BLANK_CHAR};
        tgt_row        = sweep_row_reg;
        tgt_col        = sweep_col_reg;
        tgt_logical    = 1'b0;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;

        case (state_reg)
            tccw_pkg::ST_INIT, tccw_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = 7'd0;
                    sweep_row_next = sweep_row_reg + 6'd1;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 7'd1;
                end
            end
            tccw_pkg::ST_SCROLL:
            begin
                mem_we         = 1'b1;
                sweep_col_next = sweep_col_reg + 7'd1;
            end
            tccw_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    ok_next     = 1'b1;
                    read_next   = 1'b0;
                    tgt_logical = 1'b1;
                    tgt_row     = cur_row_reg;
                    tgt_col     = cur_col_reg;
                    case (cmd.op)
                        tccw_pkg::OP_PUT, tccw_pkg::OP_NEWLINE:
                        begin
                            if (cmd.op == tccw_pkg::OP_PUT)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {cmd.attr, cmd.char_code};
                            end
                            if ((cmd.op == tccw_pkg::OP_PUT) && (cur_col_reg != LAST_COL))
                            begin
                                cur_col_next = cur_col_reg + 7'd1;
                            end
                            else
                            begin
                                cur_col_next = 7'd0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    top_next       = top_wrap_zero ? 6'd0 : top_reg + 6'd1;
                                    sweep_row_next = top_reg;
                                    sweep_col_next = 7'd0;
                                    fill_attr_next = tccw_pkg::BLANK_ATTR;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 6'd1;
                                end
                            end
                        end
                        tccw_pkg::OP_BACKSPACE:
                        begin
                            mem_wdata = {cmd.attr, tccw_pkg::BLANK_CHAR};
                            if (cur_col_reg != 7'd0)
                            begin
                                mem_we       = 1'b1;
                                cur_col_next = cur_col_reg - 7'd1;
                                tgt_col      = cur_col_reg - 7'd1;
                            end
                            else if (cur_row_reg != 6'd0)
                            begin
                                mem_we       = 1'b1;
                                cur_row_next = cur_row_reg - 6'd1;
                                cur_col_next = LAST_COL;
                                tgt_row      = cur_row_reg - 6'd1;
                                tgt_col      = LAST_COL;
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        tccw_pkg::OP_CLEAR:
                        begin
                            cur_col_next   = 7'd0;
                            cur_row_next   = 6'd0;
                            top_next       = 6'd0;
                            sweep_col_next = 7'd0;
                            sweep_row_next = 6'd0;
                            fill_attr_next = cmd.attr;
                        end
                        tccw_pkg::OP_MOVE:
                        begin
                            ok_next = cmd.on_screen;
                            if (cmd.on_screen)
                            begin
                                cur_row_next = cmd.row;
                                cur_col_next = cmd.col;
                            end
                        end
                        tccw_pkg::OP_READ:
                        begin
                            ok_next   = cmd.on_screen;
                            read_next = cmd.on_screen;
                            mem_re    = cmd.on_screen;
                            tgt_row   = cmd.row;
                            tgt_col   = cmd.col;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            tccw_pkg::ST_REPORT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // result word from the settled cursor
    always_comb
    begin
        pos_full = tccw_pkg::POS_FULL_W'(cur_row_reg) * tccw_pkg::POS_FULL_W'(COLUMNS)
                   + tccw_pkg::POS_FULL_W'(cur_col_reg);
        res.accepted   = ok_reg;
        res.cursor_pos = pos_full[10:0];
        res.cell_char  = read_reg ? rd_q[7:0] : 8'd0;
        res.cell_attr  = read_reg ? rd_q[15:8] : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccw_pkg::ST_INIT;
            cur_col_reg   <= 7'd0;
            cur_row_reg   <= 6'd0;
            top_reg       <= 6'd0;
            sweep_col_reg <= 7'd0;
            sweep_row_reg <= 6'd0;
            fill_attr_reg <= tccw_pkg::BLANK_ATTR;
            ok_reg        <= 1'b0;
            read_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            sweep_col_reg <= sweep_col_next;
            sweep_row_reg <= sweep_row_next;
            fill_attr_reg <= fill_attr_next;
            ok_reg        <= ok_next;
            read_reg      <= read_next;
        end
    end

    // cell memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[addr];
        end
    end

endmodule

// ----- rtl/text_console_char_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text-mode screen store with cursor, newline, backspace, scroll, clear,
// cursor move and cell read; one result word per input word.
// ----------------------------------------------------------------------------
// In the back end a word is first acted on in the cell memory and cursor, then
// its result is handed to the output buffer, waiting while that buffer is full.
// A put or newline that runs past the last row first blanks, cell by cell
// through the memory write port, the row that the row-offset ring brings to the
// bottom. A clear writes every cell through that port. After reset full stays
// high while the memory is filled with spaces in attribute 0x0F. Two words
// queue between front and back end and two results wait in the output buffer.
module text_console_char_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  attr,
    input  logic [5:0]  row,
    input  logic [6:0]  col,
    output logic        empty,
    input  logic        pop,
    output logic        accepted,
    output logic [10:0] cursor_pos,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_attr
);

    tccw_pkg::cmd_t    cmd_in;
    tccw_pkg::cmd_t    cmd_out;
    tccw_pkg::result_t res_in;
    tccw_pkg::result_t res_out;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_full;
    logic              res_push;
    logic              init_busy;

    assign full = cmd_full || init_busy;

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .mode      (mode),
        .char_code (char_code),
        .attr      (attr),
        .row       (row),
        .col       (col),
        .cmd       (cmd_in)
    );

    tccw_fifo #(
        .WIDTH ($bits(tccw_pkg::cmd_t))
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !init_busy),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .init_busy (init_busy)
    );

    tccw_fifo #(
        .WIDTH ($bits(tccw_pkg::result_t))
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign accepted   = res_out.accepted;
    assign cursor_pos = res_out.cursor_pos;
    assign cell_char  = res_out.cell_char;
    assign cell_attr  = res_out.cell_attr;

endmodule

// ----- dv/text_console_char_writer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_tb
// Self-checking bench for the text console writer. Directed words cover
// backspace at the origin and across a row edge, the field extremes,
// out-of-screen moves and reads, scrolling and clears. A long random mix
// follows. A shadow screen and cursor predict every result word, and the
// results are checked in order. Handshakes idle at random but in one steady run.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_tb;

    import tccw_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int STALL_LIMIT = 16 * SCREEN_CELLS;
    localparam int TAIL_CYCLES = 64;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [7:0]  attr;
    logic [5:0]  row;
    logic [6:0]  col;
    logic        empty;
    logic        pop = 1'b0;
    logic        accepted;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;

    logic [15:0] shadow_cells [0:SCREEN_CELLS-1];
    int          shadow_row;
    int          shadow_col;
    result_t     pending_results [$];
    result_t     want;
    int          failures = 0;
    int          stall_cycles;
    bit          steady = 1'b0;

    text_console_char_writer_unit #(
        .COLUMNS(SCREEN_COLS),
        .ROWS(SCREEN_ROWS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .mode(mode),
        .char_code(char_code),
        .attr(attr),
        .row(row),
        .col(col),
        .empty(empty),
        .pop(pop),
        .accepted(accepted),
        .cursor_pos(cursor_pos),
        .cell_char(cell_char),
        .cell_attr(cell_attr)
    );

    always #1 clk = ~clk;

    function automatic result_t predict_console_word(mode_t m, logic [7:0] ch,
                                                     logic [7:0] at, logic [5:0] r,
                                                     logic [6:0] c);
        result_t res;
        bit in_screen;
        res = '0;
        in_screen = (r < SCREEN_ROWS) && (c < SCREEN_COLS);
        case (m)
            MODE_PUT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    shadow_col = 0;
                    shadow_row++;
                    res.accepted = 1'b1;
                end
                else if (ch == CH_BACKSPACE)
                begin
                    if (shadow_col > 0 || shadow_row > 0)
                    begin
                        if (shadow_col > 0)
                            shadow_col--;
                        else
                        begin
                            shadow_row--;
                            shadow_col = SCREEN_COLS - 1;
                        end
                        shadow_cells[shadow_row * SCREEN_COLS + shadow_col] =
                            {at, BLANK_CHAR};
                        res.accepted = 1'b1;
                    end
                end
                else
                begin
                    shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = {at, ch};
                    shadow_col++;
                    if (shadow_col >= SCREEN_COLS)
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                    res.accepted = 1'b1;
                end
                // past the bottom row: shift up and blank the new last row
                if (shadow_row >= SCREEN_ROWS)
                begin
                    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                        shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
                    for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                        shadow_cells[i] = {BLANK_ATTR, BLANK_CHAR};
                    shadow_row = SCREEN_ROWS - 1;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < SCREEN_CELLS; i++)
                    shadow_cells[i] = {at, BLANK_CHAR};
                shadow_row = 0;
                shadow_col = 0;
                res.accepted = 1'b1;
            end
            MODE_MOVE:
            begin
                if (in_screen)
                begin
                    shadow_row = r;
                    shadow_col = c;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                if (in_screen)
                begin
                    {res.cell_attr, res.cell_char} = shadow_cells[r * SCREEN_COLS + c];
                    res.accepted = 1'b1;
                end
            end
        endcase
        res.cursor_pos = 11'(shadow_row * SCREEN_COLS + shadow_col);
        return res;
    endfunction

    task automatic send_word(input mode_t m, input logic [7:0] ch, input logic [7:0] at,
                             input logic [5:0] r, input logic [6:0] c);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        mode = m;
        char_code = ch;
        attr = at;
        row = r;
        col = c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(predict_console_word(m, ch, at, r, c));
    endtask

    task automatic wait_for_results;
        @(negedge clk);
        push = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_backspace_and_wrap;
        send_word(MODE_PUT, CH_BACKSPACE, 8'h55, 6'd0, 7'd0);
        send_word(MODE_PUT, 8'hFF, 8'hFF, 6'd63, 7'd127);
        send_word(MODE_PUT, 8'h00, 8'h00, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd0, 7'd1);
        send_word(MODE_PUT, CH_BACKSPACE, 8'h3C, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd0, 7'd1);
        send_word(MODE_PUT, CH_NEWLINE, 8'h00, 6'd0, 7'd0);
        send_word(MODE_PUT, CH_BACKSPACE, 8'h71, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd0, 7'(SCREEN_COLS - 1));
    endtask

    task automatic test_move_and_read_bounds;
        send_word(MODE_MOVE, 8'h00, 8'h00, 6'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
        send_word(MODE_MOVE, 8'h00, 8'h00, 6'(SCREEN_ROWS), 7'd0);
        send_word(MODE_MOVE, 8'h00, 8'h00, 6'd0, 7'(SCREEN_COLS));
        send_word(MODE_MOVE, 8'h00, 8'h00, 6'd63, 7'd127);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd63, 7'd127);
        send_word(MODE_READ, 8'h00, 8'h00, 6'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
    endtask

    task automatic test_scroll;
        send_word(MODE_PUT, 8'h41, 8'h1E, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'(SCREEN_ROWS - 2), 7'(SCREEN_COLS - 1));
        send_word(MODE_READ, 8'h00, 8'h00, 6'(SCREEN_ROWS - 1), 7'd0);
        send_word(MODE_PUT, CH_NEWLINE, 8'h00, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'(SCREEN_ROWS - 3), 7'(SCREEN_COLS - 1));
    endtask

    task automatic test_clear;
        send_word(MODE_CLEAR, 8'h00, 8'hA5, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd12, 7'd40);
        send_word(MODE_CLEAR, 8'h00, 8'h00, 6'd0, 7'd0);
        send_word(MODE_READ, 8'h00, 8'h00, 6'd0, 7'd0);
    endtask

    task automatic test_random_traffic(input int count, input bit with_steady_stretch);
        int    pick;
        mode_t m;
        logic [7:0] ch;
        logic [7:0] at;
        logic [5:0] r;
        logic [6:0] c;
        for (int i = 0; i < count; i++)
        begin
            steady = with_steady_stretch && i >= count / 3 && i < 2 * count / 3;
            ch = 8'($urandom_range(0, 255));
            at = 8'($urandom_range(0, 255));
            r = 6'($urandom_range(0, 63));
            c = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 999);
            if (pick < 4)
                m = MODE_CLEAR;
            else if (pick < 640)
            begin
                m = MODE_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    ch = CH_NEWLINE;
                else if (pick < 18)
                    ch = CH_BACKSPACE;
            end
            else if (pick < 800)
            begin
                m = MODE_MOVE;
                if ($urandom_range(0, 99) < 85)
                begin
                    // bias towards the bottom row so that scrolling comes often
                    if ($urandom_range(0, 99) < 30)
                        r = 6'(SCREEN_ROWS - 1);
                    else
                        r = 6'($urandom_range(0, SCREEN_ROWS - 1));
                    c = 7'($urandom_range(0, SCREEN_COLS - 1));
                end
            end
            else
            begin
                m = MODE_READ;
                if ($urandom_range(0, 99) < 80)
                begin
                    if ($urandom_range(0, 99) < 50)
                        r = 6'(shadow_row);
                    else
                        r = 6'($urandom_range(0, SCREEN_ROWS - 1));
                    c = 7'($urandom_range(0, SCREEN_COLS - 1));
                end
            end
            send_word(m, ch, at, r, c);
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
        pop = rst_n && (steady || $urandom_range(0, 99) >= 24);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: accepted %0d cursor_pos %0d",
                       accepted, cursor_pos);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (accepted !== want.accepted)
                begin
                    $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                    failures++;
                end
                if (cursor_pos !== want.cursor_pos)
                begin
                    $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos,
                           cursor_pos);
                    failures++;
                end
                if (cell_char !== want.cell_char)
                begin
                    $error("cell_char: expected %0h, actual %0h", want.cell_char, cell_char);
                    failures++;
                end
                if (cell_attr !== want.cell_attr)
                begin
                    $error("cell_attr: expected %0h, actual %0h", want.cell_attr, cell_attr);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("text_console_char_writer_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        mode = MODE_PUT;
        char_code = 8'h00;
        attr = 8'h00;
        row = 6'd0;
        col = 7'd0;
        for (int i = 0; i < SCREEN_CELLS; i++)
            shadow_cells[i] = {BLANK_ATTR, BLANK_CHAR};
        shadow_row = 0;
        shadow_col = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_backspace_and_wrap();
        test_move_and_read_bounds();
        test_scroll();
        test_clear();
        test_random_traffic(500, 1'b0);
        // hold the sender off until the block has fully drained
        wait_for_results();
        test_random_traffic(500, 1'b1);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("text_console_char_writer_unit_tb: PASS");
        else
            $display("text_console_char_writer_unit_tb: FAIL");
        $finish;
    end

endmodule
